### hdl/jdc_pkg.sv
// Shared types and constants of the Julian date to civil date and time converter.
package jdc_pkg;

   // Field widths of one transaction
   localparam int DAY_BITS      = 26;
   localparam int FRACTION_BITS = 32;
   localparam int YEAR_BITS     = 19;
   localparam int SEC_BITS      = 22;
   localparam int SEC_FRAC_BITS = 16;

   // Register stages from an accepted transaction to its result
   localparam int PIPE_DEPTH = 10;

   typedef struct packed {
      logic [DAY_BITS-1:0]      jd_days;
      logic [FRACTION_BITS-1:0] jd_fraction;
   } jdc_req_type;

   typedef struct packed {
      logic signed [YEAR_BITS-1:0] year;
      logic [3:0]                  month;
      logic [4:0]                  day_of_month;
      logic [4:0]                  hour;
      logic [5:0]                  minute;
      logic [SEC_BITS-1:0]         seconds_scaled;
      logic                        status;
   } jdc_rsp_type;

   // Calendar half of a result
   typedef struct packed {
      logic signed [YEAR_BITS-1:0] year;
      logic [3:0]                  month;
      logic [4:0]                  day_of_month;
      logic                        status;
   } jdc_date_type;

   // Time-of-day half of a result
   typedef struct packed {
      logic [4:0]          hour;
      logic [5:0]          minute;
      logic [SEC_BITS-1:0] seconds_scaled;
   } jdc_time_type;

endpackage

### hdl/jdc_date_pipe.sv
// Calendar pipeline: day count to Gregorian year, month and day in PIPE_DEPTH stages.
module jdc_date_pipe import jdc_pkg::*; (
   input  logic                clock,
   input  logic [DAY_BITS-1:0] days,
   input  logic                carry,
   output jdc_date_type        date
);

   localparam int J_BITS       = DAY_BITS + 1;
   localparam int JD_OFFSET    = 32044;
   localparam int DAYS_400Y    = 146097;
   localparam int DAYS_100Y    = 36524;
   localparam int DAYS_4Y      = 1461;
   localparam int DAYS_1Y      = 365;
   localparam int YEAR_OFFSET  = 4800;
   localparam int RECIP_400Y   = (1 << J_BITS) / DAYS_400Y;
   localparam int R400_BITS    = 10;
   localparam int P1_BITS      = J_BITS + R400_BITS;
   localparam int DC_BITS      = 16;
   localparam int RECIP_4Y     = (1 << DC_BITS) / DAYS_4Y;
   localparam int P2_BITS      = DC_BITS + 6;
   localparam int YB_BITS      = YEAR_BITS;

   // Day of the March-based year on which each month starts
   localparam logic [8:0] MONTH_START [12] =
      '{9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337};

   // Stage registers
   logic [J_BITS-1:0]    j_ff, j_in;
   logic [J_BITS-1:0]    j2_ff;
   logic [P1_BITS-1:0]   p1_ff, p1_in;
   logic [9:0]           g0_ff, g0_in;
   logic [18:0]          r0_ff, r0_in;
   logic [8:0]           g4_ff, g4_in;
   logic [17:0]          dg_ff, dg_in;
   logic [8:0]           g5_ff, g6_ff, g7_ff, g8_ff;
   logic [1:0]           c5_ff, c5_in;
   logic [1:0]           c6_ff, c7_ff, c8_ff;
   logic [DC_BITS-1:0]   dc_ff, dc_in;
   logic [DC_BITS-1:0]   dc6_ff;
   logic [P2_BITS-1:0]   p2_ff, p2_in;
   logic [5:0]           b0_ff, b0_in;
   logic [11:0]          rb_ff, rb_in;
   logic [4:0]           b_ff, b_in;
   logic [10:0]          db_ff, db_in;
   logic [8:0]           da_ff, da_in;
   logic [YB_BITS-1:0]   yb_ff, yb_in;
   jdc_date_type         date_ff, date_in;

   // Working values
   logic [J_BITS-1:0]    g0_days;
   logic [1:0]           a_sel;
   logic [3:0]           m;
   logic [8:0]           d;
   logic signed [YB_BITS:0] year_full;

   // Shift by the epoch and carry in the half-day wrap
   always_comb begin
      j_in = J_BITS'(days) + J_BITS'(carry) + J_BITS'(JD_OFFSET);
   end

   // Estimate the 400-year cycle count by reciprocal
   always_comb begin
      p1_in = P1_BITS'(j_ff) * P1_BITS'(RECIP_400Y);
   end

   // Form the remainder of the estimate
   always_comb begin
      g0_in   = p1_ff[P1_BITS-1:J_BITS];
      g0_days = J_BITS'(P1_BITS'(g0_in) * P1_BITS'(DAYS_400Y));
      r0_in   = 19'(j2_ff - g0_days);
   end

   // Correct the estimate by one where the remainder overshoots
   always_comb begin
      if (r0_ff >= 19'(DAYS_400Y)) begin
         g4_in = 9'(g0_ff + 10'd1);
         dg_in = 18'(r0_ff - 19'(DAYS_400Y));
      end else begin
         g4_in = 9'(g0_ff);
         dg_in = 18'(r0_ff);
      end
   end

   // Split the 400-year cycle into centuries, the last one long
   always_comb begin
      c5_in = 2'(dg_ff >= 18'(DAYS_100Y)) + 2'(dg_ff >= 18'(2 * DAYS_100Y))
            + 2'(dg_ff >= 18'(3 * DAYS_100Y));
      case (c5_in)
         2'd0:    dc_in = DC_BITS'(dg_ff);
         2'd1:    dc_in = DC_BITS'(dg_ff - 18'(DAYS_100Y));
         2'd2:    dc_in = DC_BITS'(dg_ff - 18'(2 * DAYS_100Y));
         default: dc_in = DC_BITS'(dg_ff - 18'(3 * DAYS_100Y));
      endcase
   end

   // Estimate the 4-year cycle count by reciprocal
   always_comb begin
      p2_in = P2_BITS'(dc_ff) * P2_BITS'(RECIP_4Y);
   end

   always_comb begin
      b0_in = p2_ff[P2_BITS-1:DC_BITS];
      rb_in = 12'(dc6_ff - DC_BITS'(DC_BITS'(b0_in) * DC_BITS'(DAYS_4Y)));
   end

   always_comb begin
      if (rb_ff >= 12'(DAYS_4Y)) begin
         b_in  = 5'(b0_ff + 6'd1);
         db_in = 11'(rb_ff - 12'(DAYS_4Y));
      end else begin
         b_in  = 5'(b0_ff);
         db_in = 11'(rb_ff);
      end
   end

   // Split the 4-year cycle into years and sum the year count
   always_comb begin
      a_sel = 2'(db_ff >= 11'(DAYS_1Y)) + 2'(db_ff >= 11'(2 * DAYS_1Y))
            + 2'(db_ff >= 11'(3 * DAYS_1Y));
      case (a_sel)
         2'd0:    da_in = 9'(db_ff);
         2'd1:    da_in = 9'(db_ff - 11'(DAYS_1Y));
         2'd2:    da_in = 9'(db_ff - 11'(2 * DAYS_1Y));
         default: da_in = 9'(db_ff - 11'(3 * DAYS_1Y));
      endcase
      yb_in = YB_BITS'(YB_BITS'(g8_ff) * YB_BITS'(400)) + YB_BITS'(YB_BITS'(c8_ff) * YB_BITS'(100))
            + YB_BITS'({b_ff, 2'b00}) + YB_BITS'(a_sel);
   end

   // Find the month from the day of the March-based year
   always_comb begin
      case (da_ff) inside
         [9'd0:9'd30]:    m = 4'd0;
         [9'd31:9'd60]:   m = 4'd1;
         [9'd61:9'd91]:   m = 4'd2;
         [9'd92:9'd121]:  m = 4'd3;
         [9'd122:9'd152]: m = 4'd4;
         [9'd153:9'd183]: m = 4'd5;
         [9'd184:9'd213]: m = 4'd6;
         [9'd214:9'd244]: m = 4'd7;
         [9'd245:9'd274]: m = 4'd8;
         [9'd275:9'd305]: m = 4'd9;
         [9'd306:9'd336]: m = 4'd10;
         [9'd337:9'd365]: m = 4'd11;
         default:         m = 4'd0;
      endcase
      d = da_ff - MONTH_START[m];
      // January and February belong to the next civil year
      year_full = $signed({1'b0, yb_ff}) - (YB_BITS+1)'(YEAR_OFFSET)
                + $signed((YB_BITS+1)'(m >= 4'd10));
      date_in.year         = year_full[YB_BITS-1:0];
      date_in.month        = (m >= 4'd10) ? 4'(m - 4'd9) : 4'(m + 4'd3);
      date_in.day_of_month = 5'(d + 9'd1);
      date_in.status       = year_full[YB_BITS] || (year_full == '0);
   end

   // Advance every stage on each cycle
   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      p1_ff   <= p1_in;
      j2_ff   <= j_ff;
      g0_ff   <= g0_in;
      r0_ff   <= r0_in;
      g4_ff   <= g4_in;
      dg_ff   <= dg_in;
      g5_ff   <= g4_ff;
      c5_ff   <= c5_in;
      dc_ff   <= dc_in;
      g6_ff   <= g5_ff;
      c6_ff   <= c5_ff;
      dc6_ff  <= dc_ff;
      p2_ff   <= p2_in;
      g7_ff   <= g6_ff;
      c7_ff   <= c6_ff;
      b0_ff   <= b0_in;
      rb_ff   <= rb_in;
      g8_ff   <= g7_ff;
      c8_ff   <= c7_ff;
      b_ff    <= b_in;
      db_ff   <= db_in;
      da_ff   <= da_in;
      yb_ff   <= yb_in;
      date_ff <= date_in;
   end

   assign date = date_ff;

endmodule

### hdl/jdc_time_pipe.sv
// Time-of-day pipeline: day fraction to hour, minute and scaled seconds.
module jdc_time_pipe import jdc_pkg::*; (
   input  logic                     clock,
   input  logic [FRACTION_BITS-1:0] tod,
   output jdc_time_type             tod_out
);

   localparam int T24_BITS    = FRACTION_BITS + 5;
   localparam int T60_BITS    = FRACTION_BITS + 6;
   localparam int TIME_DELAY  = PIPE_DEPTH - 3;

   logic [T24_BITS-1:0] t24_ff, t24_in;
   logic [T60_BITS-1:0] t60_ff, t60_in;
   logic [T60_BITS-1:0] s60_ff, s60_in;
   logic [4:0]          hour2_ff, hour3_ff;
   logic [5:0]          minute_ff;
   jdc_time_type        stage3;
   jdc_time_type        dly_ff [TIME_DELAY];

   // Scale the fraction by hours, then minutes, then seconds
   always_comb begin
      t24_in = T24_BITS'(tod) * T24_BITS'(24);
      t60_in = T60_BITS'(t24_ff[FRACTION_BITS-1:0]) * T60_BITS'(60);
      s60_in = T60_BITS'(t60_ff[FRACTION_BITS-1:0]) * T60_BITS'(60);
   end

   always_comb begin
      stage3.hour           = hour3_ff;
      stage3.minute         = minute_ff;
      stage3.seconds_scaled = s60_ff[T60_BITS-1:FRACTION_BITS-SEC_FRAC_BITS];
   end

   // Advance the stages and hold results level with the calendar side
   always_ff @(posedge clock) begin
      t24_ff    <= t24_in;
      t60_ff    <= t60_in;
      hour2_ff  <= t24_ff[T24_BITS-1:FRACTION_BITS];
      s60_ff    <= s60_in;
      minute_ff <= t60_ff[T60_BITS-1:FRACTION_BITS];
      hour3_ff  <= hour2_ff;
      dly_ff[0] <= stage3;
      for (int i = 1; i < TIME_DELAY; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign tod_out = dly_ff[TIME_DELAY-1];

endmodule

### hdl/julian_date_to_civil_date_time_top.sv
// Top level of the Julian date to civil date and time converter.
//
//   channel   ports                        handshake
//   request   start, busy, req_data        taken when start high and busy low
//   response  rsp_strobe, rsp_data         one cycle per result, never held off
//
// Each transaction passes through every pipeline stage before its result appears, one
// transaction per cycle; the depth is set by the two reciprocal divisions of
// the calendar pipeline, each a multiply, a remainder and a correction stage.
// busy stays low: every stage advances on every cycle.
// Synchronous reset drops all transactions in flight; payload registers keep no reset.
module julian_date_to_civil_date_time_top import jdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  jdc_req_type req_data,
   output logic        rsp_strobe,
   output jdc_rsp_type rsp_data
);

   logic [PIPE_DEPTH-1:0]    valid_ff, valid_in;
   logic                     carry;
   logic [FRACTION_BITS-1:0] tod;
   jdc_date_type             date;
   jdc_time_type             tod_out;

   // Add half a day: the top fraction bit flips and carries into the day count
   assign carry = req_data.jd_fraction[FRACTION_BITS-1];
   assign tod   = {~req_data.jd_fraction[FRACTION_BITS-1],
                   req_data.jd_fraction[FRACTION_BITS-2:0]};

   jdc_date_pipe u_date (
      .clock (clock),
      .days  (req_data.jd_days),
      .carry (carry),
      .date  (date)
   );

   jdc_time_pipe u_time (
      .clock   (clock),
      .tod     (tod),
      .tod_out (tod_out)
   );

   // Carry a valid bit alongside each transaction
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign busy       = 1'b0;
   assign rsp_strobe = valid_ff[PIPE_DEPTH-1];

   always_comb begin
      rsp_data.year           = date.year;
      rsp_data.month          = date.month;
      rsp_data.day_of_month   = date.day_of_month;
      rsp_data.hour           = tod_out.hour;
      rsp_data.minute         = tod_out.minute;
      rsp_data.seconds_scaled = tod_out.seconds_scaled;
      rsp_data.status         = date.status;
   end

endmodule

### hdl/jdc_checker.sv
// Port-level checker of the converter and its bind to the top level.
module jdc_port_checker import jdc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input jdc_rsp_type rsp_data
);

   // Each result follows a taken transaction by the pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without a transaction taken PIPE_DEPTH cycles before");

   // Reset drops everything in flight
   a_reset_drop: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe straight after reset");

   // Calendar fields stay in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.month >= 4'd1 && rsp_data.month <= 4'd12 &&
                      rsp_data.day_of_month >= 5'd1 && rsp_data.day_of_month <= 5'd31))
      else $error("month or day out of range");

   // Time fields stay in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.hour <= 5'd23 && rsp_data.minute <= 6'd59 &&
                      rsp_data.seconds_scaled <= 22'd3932159))
      else $error("time of day out of range");

   // Status flags exactly the non-positive years
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status == (rsp_data.year <= 0)))
      else $error("status disagrees with year");

endmodule

bind julian_date_to_civil_date_time_top jdc_port_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
